### hw/rtl/bdq_pkg.sv
// Shared types and constants for the bounded deque block.
// No dependencies; every other file of the block imports this package.
package bdq_pkg;

  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = $clog2(CAPACITY_DEF + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_REMOVE     = 3'd4,
    REQ_CLEAR      = 3'd5,
    REQ_GET        = 3'd6
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } seq_state_e;

endpackage

### hw/rtl/bdq_if.sv
// Request and response channel interfaces (valid/ready) of the deque block.
// Depends on bdq_pkg for field widths.
interface bdq_req_if import bdq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]        index;

  modport source (output valid, output req_type, output value, output index, input ready);
  modport sink   (input valid, input req_type, input value, input index, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; #(
  parameter int unsigned CNT_W = COUNT_W
) ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] read_value;
  logic [CNT_W-1:0]          count;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, output read_value, output count, output status, input ready);
  modport sink   (input valid, input read_value, input count, input status, output ready);
endinterface

### hw/rtl/bdq_mem.sv
// Element store: one write port, one read port with registered read data.
// Depends on bdq_pkg for default widths.
module bdq_mem import bdq_pkg::*; #(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned DW    = DATA_WIDTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bdq_seq.sv
// Request sequencer: front/count state, shared slot adder and compare, remove scan.
// Depends on bdq_pkg; drives the ports of bdq_mem.
module bdq_seq import bdq_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned AW         = $clog2(CAPACITY),
  parameter int unsigned CW         = $clog2(CAPACITY + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  output logic                      idle_o,
  input  logic                      accept_i,
  input  req_e                      req_type_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic [INDEX_W-1:0]        index_i,
  output logic                      res_valid_o,
  output logic signed [VALUE_W-1:0] res_read_value_o,
  output logic [CW-1:0]             res_count_o,
  output status_e                   res_status_o,
  output logic                      mem_we_o,
  output logic [AW-1:0]             mem_waddr_o,
  output logic [DATA_WIDTH-1:0]     mem_wdata_o,
  output logic                      mem_re_o,
  output logic [AW-1:0]             mem_raddr_o,
  input  logic [DATA_WIDTH-1:0]     mem_rdata_i
);

  localparam int unsigned PW = (CW > INDEX_W) ? CW : INDEX_W;

  seq_state_e state_q, state_d;
  logic [AW-1:0]         front_q, front_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         pos_q, pos_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;

  logic [DATA_WIDTH-1:0] in_val;
  logic [PW-1:0]         idx_ext;
  logic [CW-1:0]         pos_sel;
  logic [CW:0]           slot_sum;
  logic [AW-1:0]         slot;
  logic [AW-1:0]         front_dec;
  logic                  full;

  assign in_val    = DATA_WIDTH'(value_i);
  assign idx_ext   = PW'(index_i);
  assign full      = (count_q == CW'(CAPACITY));
  assign front_dec = (front_q == '0) ? AW'(CAPACITY - 1) : front_q - AW'(1);

  // shared slot unit: (front + pos) mod CAPACITY, pos <= CAPACITY
  always_comb begin
    slot_sum = (CW + 1)'(front_q) + (CW + 1)'(pos_sel);
    if (slot_sum >= (CW + 1)'(CAPACITY)) begin
      slot_sum = slot_sum - (CW + 1)'(CAPACITY);
    end
    slot = AW'(slot_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_comb begin
    state_d          = state_q;
    front_d          = front_q;
    count_d          = count_q;
    pos_d            = pos_q;
    val_d            = val_q;
    pos_sel          = pos_q;
    idle_o           = 1'b0;
    res_valid_o      = 1'b0;
    res_read_value_o = '0;
    res_status_o     = ST_OK;
    mem_we_o         = 1'b0;
    mem_waddr_o      = slot;
    mem_wdata_o      = val_q;
    mem_re_o         = 1'b0;
    mem_raddr_o      = slot;

    case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        case (req_type_i)
          REQ_PUSH_BACK: pos_sel = count_q;
          REQ_POP_FRONT: pos_sel = CW'(1);
          REQ_GET:       pos_sel = CW'(idx_ext);
          default:       pos_sel = pos_q;
        endcase
        if (accept_i) begin
          res_valid_o = 1'b1;
          case (req_type_i)
            REQ_PUSH_BACK: begin
              if (full) begin
                res_status_o = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_wdata_o = in_val;
                count_d     = count_q + CW'(1);
              end
            end
            REQ_PUSH_FRONT: begin
              if (full) begin
                res_status_o = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = front_dec;
                mem_wdata_o = in_val;
                front_d     = front_dec;
                count_d     = count_q + CW'(1);
              end
            end
            REQ_POP_BACK: begin
              if (count_q == '0) begin
                res_status_o = ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                if (count_q == CW'(1)) front_d = '0;
              end
            end
            REQ_POP_FRONT: begin
              if (count_q == '0) begin
                res_status_o = ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                front_d = (count_q == CW'(1)) ? '0 : slot;
              end
            end
            REQ_REMOVE: begin
              res_valid_o = 1'b0;
              val_d       = in_val;
              pos_d       = '0;
              state_d     = S_SCAN_RD;
            end
            REQ_CLEAR: begin
              front_d = '0;
              count_d = '0;
            end
            REQ_GET: begin
              if (idx_ext >= PW'(count_q)) begin
                res_status_o = ST_RANGE;
              end else begin
                res_valid_o = 1'b0;
                mem_re_o    = 1'b1;
                state_d     = S_GET;
              end
            end
            default: ;
          endcase
        end
      end
      S_GET: begin
        res_valid_o      = 1'b1;
        res_read_value_o = VALUE_W'($signed(mem_rdata_i));
        state_d          = S_IDLE;
      end
      // search: read slot(pos), compare the next cycle
      S_SCAN_RD: begin
        if (pos_q == count_q) begin
          res_valid_o  = 1'b1;
          res_status_o = ST_NOT_FOUND;
          state_d      = S_IDLE;
        end else begin
          mem_re_o = 1'b1;
          state_d  = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (mem_rdata_i == val_q) begin
          state_d = S_SHIFT_RD;
        end else begin
          pos_d   = pos_q + CW'(1);
          state_d = S_SCAN_RD;
        end
      end
      // compaction: move slot(pos+1) into slot(pos) until the tail
      S_SHIFT_RD: begin
        pos_sel = pos_q + CW'(1);
        if ((pos_q + CW'(1)) >= count_q) begin
          res_valid_o = 1'b1;
          count_d     = count_q - CW'(1);
          if (count_q == CW'(1)) front_d = '0;
          state_d     = S_IDLE;
        end else begin
          mem_re_o = 1'b1;
          state_d  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i;
        pos_d       = pos_q + CW'(1);
        state_d     = S_SHIFT_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_count_o = count_d;

endmodule

### hw/rtl/bounded_deque_with_remove.sv
// Bounded deque with remove-by-value. Push, pop, clear and out-of-range get: the result
// beat is registered at acceptance and shows in the cycle after; an in-range get reads the store first.
// Remove scans the list for the value, then moves each later element one place toward the
// front; the store ports and the shared slot adder carry both the scan and the move.
// One item at a time: ready while idle and the result register is free or being taken.
// Reset (async, active low) empties the list; store contents stay undefined, no clear pass.
module bounded_deque_with_remove import bdq_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bdq_req_if.sink  req_i,
  bdq_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // sequencer handshake
  logic                      seq_idle;
  logic                      accept;
  logic                      res_valid;
  logic signed [VALUE_W-1:0] res_read_value;
  logic [CW-1:0]             res_count;
  status_e                   res_status;

  // store port
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // result register
  logic                      out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] out_value_q;
  logic [CW-1:0]             out_count_q;
  status_e                   out_status_q;

  // a new request may enter only when its result beat has a free slot to land in
  assign req_i.ready = seq_idle && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  bdq_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .idle_o           (seq_idle),
    .accept_i         (accept),
    .req_type_i       (req_e'(req_i.req_type)),
    .value_i          (req_i.value),
    .index_i          (req_i.index),
    .res_valid_o      (res_valid),
    .res_read_value_o (res_read_value),
    .res_count_o      (res_count),
    .res_status_o     (res_status),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

  bdq_mem #(
    .DEPTH (CAPACITY),
    .DW    (DATA_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // result beat: a multi-cycle op only starts with the register free, so a new
  // result never overwrites one still waiting
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_value_q  <= res_read_value;
      out_count_q  <= res_count;
      out_status_q <= res_status;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_value = out_value_q;
  assign rsp_o.count      = out_count_q;
  assign rsp_o.status     = out_status_q;

endmodule

### tb/bdq_checker.sv
// Response checker for the bounded deque: shadows the list state and compares result beats.
// Depends on bdq_pkg and the bdq_req_if / bdq_rsp_if channel interfaces.
`timescale 1ns / 100ps

module bdq_checker import bdq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdq_req_if          req_i,
  bdq_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        count;
    status_e                   status;
  } deque_result_t;

  // shadow copy of the list
  logic signed [VALUE_W-1:0] list_store [CAPACITY_DEF];
  int unsigned               list_front;
  int unsigned               list_count;

  deque_result_t awaited_responses [$];
  deque_result_t want;

  function automatic int unsigned slot_at(input int unsigned pos);
    return (list_front + pos) % CAPACITY_DEF;
  endfunction

  // Applies one request to the shadow list and returns the beat it should produce.
  function automatic deque_result_t predict_deque_op(input req_e kind,
                                                     input logic signed [VALUE_W-1:0] val,
                                                     input logic [INDEX_W-1:0] idx);
    deque_result_t res;
    int unsigned   pos;
    res.read_value = '0;
    res.status     = ST_OK;
    case (kind)
      REQ_PUSH_BACK: begin
        if (list_count >= CAPACITY_DEF) begin
          res.status = ST_FULL;
        end else begin
          list_store[slot_at(list_count)] = val;
          list_count++;
        end
      end
      REQ_PUSH_FRONT: begin
        if (list_count >= CAPACITY_DEF) begin
          res.status = ST_FULL;
        end else begin
          list_front = (list_front + CAPACITY_DEF - 1) % CAPACITY_DEF;
          list_store[list_front] = val;
          list_count++;
        end
      end
      REQ_POP_BACK: begin
        if (list_count == 0) res.status = ST_EMPTY;
        else list_count--;
      end
      REQ_POP_FRONT: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          list_front = slot_at(1);
          list_count--;
        end
      end
      REQ_REMOVE: begin
        pos = 0;
        while (pos < list_count && list_store[slot_at(pos)] !== val) pos++;
        if (pos >= list_count) begin
          res.status = ST_NOT_FOUND;
        end else begin
          // later elements slide one place toward the front
          while (pos + 1 < list_count) begin
            list_store[slot_at(pos)] = list_store[slot_at(pos + 1)];
            pos++;
          end
          list_count--;
        end
      end
      REQ_CLEAR: begin
        list_front = 0;
        list_count = 0;
      end
      REQ_GET: begin
        if (idx >= list_count) res.status = ST_RANGE;
        else res.read_value = list_store[slot_at(idx)];
      end
      default: ;
    endcase
    // an emptied list always restarts at slot zero
    if (list_count == 0) list_front = 0;
    res.count = list_count[COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_front   = 0;
      list_count   = 0;
      awaited_responses.delete();
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      // a result beat always belongs to an earlier request, so check it first
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (awaited_responses.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing awaited: value %h count %0d status %0d",
                                    rsp_i.read_value, rsp_i.count, rsp_i.status));
        end else begin
          want = awaited_responses[0];
          awaited_responses.delete(0);
          if (rsp_i.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %h, expected %h",
                                      rsp_i.read_value, want.read_value));
          if (rsp_i.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", rsp_i.count, want.count));
          if (rsp_i.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d (%s)",
                                      rsp_i.status, want.status, want.status.name()));
        end
      end
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1)
        awaited_responses.insert(awaited_responses.size(),
                                 predict_deque_op(req_e'(req_i.req_type),
                                                  req_i.value, req_i.index));
      pending_o <= awaited_responses.size();
    end
  end

endmodule

### tb/tb_bounded_deque_with_remove.sv
// Top of the deque testbench: clock, reset, request and response drivers, and the verdict.
// Depends on bdq_pkg, the channel interfaces, bounded_deque_with_remove and bdq_checker.
`timescale 1ns / 100ps

module tb_bounded_deque_with_remove;
  import bdq_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 700;   // on top of the full-list pass
  localparam int unsigned POOL_SIZE       = 12;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned END_WAIT        = 12;
  // A remove on a full list and the long hold-off give the longest gaps between beats;
  // the limit is several times the worst of those between two accepted beats.
  localparam int unsigned STALL_LIMIT     = 6000;

  typedef enum int unsigned {
    MIX_GROW,
    MIX_CHURN,
    MIX_SHRINK
  } mix_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bdq_req_if req_bus ();
  bdq_rsp_if rsp_bus ();

  int unsigned checker_fails;
  int unsigned checker_pending;

  // idle percentages for each side, changed per phase
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  // set by the stimulus, cleared by the response driver once the hold-off is over
  bit          hold_off_req = 1'b0;

  logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];

  int unsigned stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  bounded_deque_with_remove dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  bdq_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_bus),
    .rsp_i        (rsp_bus),
    .fail_count_o (checker_fails),
    .pending_o    (checker_pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(12, 48);
  endfunction

  // Request mix per phase; weights follow req_e order and sum to 100.
  function automatic req_e pick_request(input mix_e mix);
    int unsigned w [7];
    int unsigned r;
    case (mix)
      MIX_GROW:  w = '{30, 25, 8, 7, 10, 1, 19};
      MIX_CHURN: w = '{18, 15, 15, 14, 15, 1, 22};
      default:   w = '{5, 5, 25, 25, 15, 2, 23};
    endcase
    r = $urandom_range(99);
    for (int k = 0; k < 7; k++) begin
      if (r < w[k]) return req_e'(k);
      r -= w[k];
    end
    return REQ_GET;
  endfunction

  // Pool values make removes hit often; raw random values toggle every bit.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(3) != 0) return value_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // Lists stay short in the random part, so favor low indexes.
  function automatic logic [INDEX_W-1:0] pick_index();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return INDEX_W'($urandom_range(0, 15));
    if (r < 90) return INDEX_W'($urandom_range(0, 63));
    return INDEX_W'($urandom_range(0, 255));
  endfunction

  // Entered and left at a falling edge. Optional gap, then one beat held until taken.
  task automatic send_beat(input req_e kind, input logic signed [VALUE_W-1:0] val,
                           input logic [INDEX_W-1:0] idx);
    int unsigned gap;
    gap = ($urandom_range(99) < src_idle_pct) ? gap_len() : 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.value    <= val;
    req_bus.index    <= idx;
    @(posedge clk_i);
    while (req_bus.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sender goes quiet until every awaited result beat has come back.
  task automatic drain();
    req_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (checker_pending != 0) @(negedge clk_i);
  endtask

  // Response side: random ready pattern, plus one long hold-off on request.
  initial begin
    rsp_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if ($urandom_range(99) < snk_idle_pct) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap_len() - 1) @(negedge clk_i);
      end else begin
        rsp_bus.ready <= 1'b1;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
        (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("tb_bounded_deque_with_remove failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic signed [VALUE_W-1:0] first_val;
    logic signed [VALUE_W-1:0] last_val;
    logic signed [VALUE_W-1:0] val;
    int unsigned               random_sent;
    int unsigned               run_len;
    mix_e                      mix;

    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_PUSH_BACK;
    req_bus.value    = '0;
    req_bus.index    = '0;

    value_pool[0] = 32'sh7FFF_FFFF;
    value_pool[1] = 32'sh8000_0000;
    value_pool[2] = '0;
    value_pool[3] = -32'sd1;
    for (int p = 4; p < POOL_SIZE; p++) value_pool[p] = $urandom();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- directed: empty-list cases, extremes, middle remove, wrap and reset of the front
    src_idle_pct = 20;
    snk_idle_pct = 20;
    send_beat(REQ_POP_BACK,   '0, '0);            // pop on empty
    send_beat(REQ_POP_FRONT,  '0, '0);
    send_beat(REQ_REMOVE,     32'sd5, '0);        // nothing to find
    send_beat(REQ_GET,        '0, '0);            // index past an empty list
    send_beat(REQ_PUSH_BACK,  32'sh7FFF_FFFF, '0);
    send_beat(REQ_PUSH_FRONT, 32'sh8000_0000, '0); // front wraps to the top slot
    send_beat(REQ_PUSH_BACK,  -32'sd1, '0);
    send_beat(REQ_PUSH_BACK,  '0, '0);
    send_beat(REQ_GET,        '0, 8'd0);
    send_beat(REQ_GET,        '0, 8'd3);
    send_beat(REQ_GET,        '0, 8'd4);          // one past the end
    send_beat(REQ_GET,        '0, 8'd255);
    send_beat(REQ_REMOVE,     -32'sd1, '0);       // middle element, tail closes the gap
    send_beat(REQ_GET,        '0, 8'd2);
    send_beat(REQ_REMOVE,     32'sd12345, '0);    // no match
    send_beat(REQ_REMOVE,     32'sh8000_0000, '0); // head element
    send_beat(REQ_POP_FRONT,  '0, '0);
    send_beat(REQ_POP_BACK,   '0, '0);            // last one out from the back
    send_beat(REQ_PUSH_FRONT, 32'sh1234_5678, '0);
    send_beat(REQ_PUSH_BACK,  32'sh0BAD_F00D, '0);
    send_beat(REQ_CLEAR,      '0, '0);
    send_beat(REQ_GET,        '0, '0);
    send_beat(REQ_PUSH_FRONT, 32'sh5A5A_5A5A, '0);
    send_beat(REQ_POP_BACK,   '0, '0);
    drain();

    // ---- full list: receiver holds off while pushes keep coming, so input stalls
    src_idle_pct = 0;
    snk_idle_pct = 10;
    hold_off_req = 1'b1;
    first_val = $urandom();
    send_beat(REQ_PUSH_BACK, first_val, pick_index());
    for (int n = 1; n < CAPACITY_DEF; n++) begin
      val = $urandom();
      if (n == CAPACITY_DEF - 1) last_val = val;
      send_beat(REQ_PUSH_BACK, val, pick_index());
    end
    send_beat(REQ_PUSH_BACK,  $urandom(), '0);    // full: dropped
    send_beat(REQ_PUSH_FRONT, $urandom(), '0);
    send_beat(REQ_GET,        '0, 8'd255);
    send_beat(REQ_GET,        '0, pick_index());
    send_beat(REQ_REMOVE,     first_val, '0);     // longest compaction
    send_beat(REQ_REMOVE,     last_val, '0);      // longest scan
    send_beat(REQ_REMOVE,     32'sh7FFF_FFFE, '0);
    send_beat(REQ_PUSH_FRONT, $urandom(), '0);
    send_beat(REQ_GET,        '0, 8'd0);
    send_beat(REQ_CLEAR,      '0, '0);
    drain();

    // ---- random runs, each with its own request mix and idle levels
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      run_len = $urandom_range(30, 80);
      mix     = mix_e'($urandom_range(2));
      case ($urandom_range(3))
        0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end  // back-to-back stretch
        1: begin src_idle_pct = 20; snk_idle_pct = 20; end
        2: begin src_idle_pct = 50; snk_idle_pct = 10; end
        default: begin src_idle_pct = 10; snk_idle_pct = 50; end
      endcase
      for (int n = 0; n < run_len; n++) begin
        send_beat(pick_request(mix), pick_value(), pick_index());
        random_sent++;
      end
      if ($urandom_range(3) == 0) drain();
    end

    drain();
    repeat (END_WAIT) @(negedge clk_i);

    if (checker_fails == 0 && checker_pending == 0) begin
      $display("tb_bounded_deque_with_remove passed");
    end else begin
      $display("tb_bounded_deque_with_remove failed");
    end
    $finish;
  end

endmodule
